@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MWF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MWF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MWF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MWF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ src/mwf_pkg.sv @@
// Package: sizes, codes and control types of the midpoint window filter.
package mwf_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 3;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int BURST      = MAX_RADIUS + 1;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int OFS_W  = $clog2(2 * MAX_RADIUS + 1);
  localparam int RING_W = $clog2(RING_ROWS);
  localparam int CNT_W  = $clog2(BURST + 1);
  localparam int ADDR_W = $clog2(RING_ROWS * MAX_WIDTH);
  localparam int SY_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 3;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic rd_issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic start_emit;
    logic scan_last;
    logic out_free;
    logic item_done;
  } sts_t;
endpackage

@@ src/mwf_in_if.sv @@
// Input channel: one raster pixel or a flush word.
interface mwf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       is_flush;
  modport source (output valid, red_in, green_in, blue_in, is_flush, input ready);
  modport sink (input valid, red_in, green_in, blue_in, is_flush, output ready);
endinterface

@@ src/mwf_out_if.sv @@
// Result channel: one filtered pixel with run and frame marks.
interface mwf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       run_last;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, run_last, frame_end,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, run_last, frame_end,
                output ready);
endinterface

@@ src/midpoint_window_filter_core.sv @@
// Top level: midpoint window filter, controller plus datapath.
//
//  channel  | dir | word
//  in_px    | in  | red_in, green_in, blue_in, is_flush
//  out_px   | out | red_out, green_out, blue_out, run_last, frame_end
//  cfg_*    | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// Each result is built by a window scan: one line store read per window tap on
// the single read port, a drain state for the last read, then a load of the
// output register. A row end releases up to MAX_RADIUS+1 results back to back.
// Out stalls hold the scan. Reset clears counters and sets config to defaults;
// the line store is not cleared.
`include "assert_macros.svh"
module midpoint_window_filter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  mwf_in_if.sink                        in_px,
  mwf_out_if.source                     out_px,
  input  logic                          cfg_we,
  input  logic [mwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mwf_pkg::CFG_W-1:0]     cfg_wdata
);
  mwf_pkg::cmd_t cmd;
  mwf_pkg::sts_t sts;

  mwf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  mwf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_px),
    .out_px    (out_px),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  `MWF_ASSERT(a_emit_free, clk, rst_n, !cmd.emit || sts.out_free, "emit into busy output")
  `MWF_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_px.valid, "emitted word not valid")
  `MWF_ASSERT_NEXT(a_done_ready, clk, rst_n, cmd.emit && sts.item_done, in_px.ready, "not ready after last result")
endmodule

@@ src/mwf_ctrl.sv @@
// Controller: sequences pixel accept, window scan and result hand-off.
module mwf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  mwf_pkg::sts_t  sts,
  output mwf_pkg::cmd_t  cmd
);
  mwf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mwf_pkg::ST_IDLE: begin
        if (sts.accept && sts.start_emit) state_nxt = mwf_pkg::ST_SCAN;
      end
      mwf_pkg::ST_SCAN: begin
        if (sts.scan_last) state_nxt = mwf_pkg::ST_DRAIN;
      end
      mwf_pkg::ST_DRAIN: state_nxt = mwf_pkg::ST_EMIT;
      mwf_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.item_done ? mwf_pkg::ST_IDLE : mwf_pkg::ST_SCAN;
        end
      end
      default: state_nxt = mwf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      mwf_pkg::ST_IDLE:  cmd.in_ready = 1'b1;
      mwf_pkg::ST_SCAN:  cmd.rd_issue = 1'b1;
      mwf_pkg::ST_DRAIN: cmd = '0;
      mwf_pkg::ST_EMIT:  cmd.emit = sts.out_free;
      default:           cmd = '0;
    endcase
  end
endmodule

@@ src/mwf_datapath.sv @@
// Datapath: config, position counters, line store, min/max scan and output register.
module mwf_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  mwf_in_if.sink                            in_px,
  mwf_out_if.source                         out_px,
  input  logic                              cfg_we,
  input  logic [mwf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwf_pkg::CFG_W-1:0]         cfg_wdata,
  input  mwf_pkg::cmd_t                     cmd,
  output mwf_pkg::sts_t                     sts
);
  localparam int COL_W  = mwf_pkg::COL_W;
  localparam int ROW_W  = mwf_pkg::ROW_W;
  localparam int RAD_W  = mwf_pkg::RAD_W;
  localparam int OFS_W  = mwf_pkg::OFS_W;
  localparam int RING_W = mwf_pkg::RING_W;
  localparam int CNT_W  = mwf_pkg::CNT_W;
  localparam int ADDR_W = mwf_pkg::ADDR_W;
  localparam int SY_W   = mwf_pkg::SY_W;
  localparam int PIX_W  = mwf_pkg::PIX_W;
  localparam int DEPTH  = mwf_pkg::RING_ROWS * mwf_pkg::MAX_WIDTH;

  logic [1:0]                 radius_cfg_r;
  logic [mwf_pkg::CFG_W-1:0]  width_cfg_r, height_cfg_r;
  logic [RAD_W-1:0]           eff_r;
  logic [COL_W:0]             eff_w;
  logic [ROW_W:0]             eff_h;
  logic [COL_W-1:0]           wm1;
  logic [ROW_W-1:0]           hm1;

  logic [COL_W-1:0]  in_col_r;
  logic [ROW_W:0]    in_row_r;
  logic [RING_W-1:0] in_ring_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [RING_W-1:0] out_ring_r;
  logic [OFS_W-1:0]  dy_r, dx_r;
  logic [CNT_W-1:0]  rem_r;

  logic [7:0] mn_r [3];
  logic [7:0] mx_r [3];
  logic       rd_vld_r;
  logic [PIX_W-1:0] rd_data_r;
  logic [PIX_W-1:0] mem [DEPTH];

  logic       out_valid_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_last_r, out_fend_r;

  // config clamping
  always_comb begin
    eff_r = (32'(radius_cfg_r) > mwf_pkg::MAX_RADIUS) ? RAD_W'(mwf_pkg::MAX_RADIUS)
                                                     : RAD_W'(radius_cfg_r);
    if (width_cfg_r == '0) eff_w = (COL_W+1)'(1);
    else if (32'(width_cfg_r) > mwf_pkg::MAX_WIDTH) eff_w = (COL_W+1)'(mwf_pkg::MAX_WIDTH);
    else eff_w = (COL_W+1)'(width_cfg_r);
    if (height_cfg_r == '0) eff_h = (ROW_W+1)'(1);
    else if (32'(height_cfg_r) > mwf_pkg::MAX_HEIGHT) eff_h = (ROW_W+1)'(mwf_pkg::MAX_HEIGHT);
    else eff_h = (ROW_W+1)'(height_cfg_r);
  end

  logic [COL_W:0] wm1_x;
  logic [ROW_W:0] hm1_x;
  assign wm1_x = eff_w - (COL_W+1)'(1);
  assign hm1_x = eff_h - (ROW_W+1)'(1);
  assign wm1   = wm1_x[COL_W-1:0];
  assign hm1   = hm1_x[ROW_W-1:0];

  // accept decision
  logic             accept, flush_emit, pix, row_end, row_ok;
  logic [COL_W-1:0] col_c;
  logic [COL_W:0]   oc_left;
  logic [CNT_W-1:0] burst, emit_cnt;

  always_comb begin
    accept     = in_px.valid && cmd.in_ready;
    flush_emit = in_row_r >= eff_h;
    pix        = !flush_emit && !in_px.is_flush;
    col_c      = ({1'b0, in_col_r} < eff_w) ? in_col_r : wm1;
    row_end    = col_c >= wm1;
    row_ok     = in_row_r >= (ROW_W+1)'(eff_r);
    oc_left    = eff_w - {1'b0, out_col_r};
    burst      = (32'(oc_left) > mwf_pkg::BURST) ? CNT_W'(mwf_pkg::BURST)
                                                 : CNT_W'(oc_left);
    emit_cnt   = '0;
    if (flush_emit) begin
      emit_cnt = CNT_W'(1);
    end else if (pix && row_ok) begin
      if (row_end) emit_cnt = burst;
      else if (col_c >= COL_W'(eff_r)) emit_cnt = CNT_W'(1);
    end
  end

  // window address
  logic signed [SY_W-1:0] sy, sx, dlt, ring_t;
  logic [ROW_W-1:0]       ny;
  logic [COL_W-1:0]       nx;
  logic [RING_W-1:0]      rd_ring;
  logic [ADDR_W-1:0]      rd_addr, wr_addr;

  always_comb begin
    sy = $signed(SY_W'(out_row_r)) + $signed(SY_W'(dy_r)) - $signed(SY_W'(eff_r));
    sx = $signed(SY_W'(out_col_r)) + $signed(SY_W'(dx_r)) - $signed(SY_W'(eff_r));
    if (sy < 0) ny = '0;
    else if (sy > $signed(SY_W'(hm1))) ny = hm1;
    else ny = sy[ROW_W-1:0];
    if (sx < 0) nx = '0;
    else if (sx > $signed(SY_W'(wm1))) nx = wm1;
    else nx = sx[COL_W-1:0];
    dlt    = $signed(SY_W'(ny)) - $signed(SY_W'(out_row_r));
    ring_t = $signed(SY_W'(out_ring_r)) + dlt;
    if (ring_t < 0) ring_t = ring_t + $signed(SY_W'(mwf_pkg::RING_ROWS));
    else if (ring_t >= $signed(SY_W'(mwf_pkg::RING_ROWS)))
      ring_t = ring_t - $signed(SY_W'(mwf_pkg::RING_ROWS));
    rd_ring = ring_t[RING_W-1:0];
    rd_addr = ADDR_W'(rd_ring) * ADDR_W'(mwf_pkg::MAX_WIDTH) + ADDR_W'(nx);
    wr_addr = ADDR_W'(in_ring_r) * ADDR_W'(mwf_pkg::MAX_WIDTH) + ADDR_W'(col_c);
  end

  logic scan_last, frame_last, item_done;
  logic [OFS_W-1:0] span;
  assign span       = OFS_W'({eff_r, 1'b0});
  assign scan_last  = (dy_r == span) && (dx_r == span);
  assign frame_last = (out_row_r >= hm1) && (out_col_r >= wm1);
  assign item_done  = frame_last || (rem_r == CNT_W'(1));

  // midpoints
  logic [8:0] sum_c [3];
  logic [7:0] mid_c [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = {1'b0, mn_r[c]} + {1'b0, mx_r[c]};
      mid_c[c] = sum_c[c][8:1];
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (accept && pix) mem[wr_addr] <= {in_px.red_in, in_px.green_in, in_px.blue_in};
    if (cmd.rd_issue) rd_data_r <= mem[rd_addr];
  end

  // counters and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_cfg_r <= 2'd1;
      width_cfg_r  <= mwf_pkg::CFG_W'(1024);
      height_cfg_r <= mwf_pkg::CFG_W'(1024);
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_ring_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_ring_r   <= '0;
      dy_r         <= '0;
      dx_r         <= '0;
      rem_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
      if (cfg_we) begin
        unique case (cfg_index)
          mwf_pkg::CFG_RADIUS: radius_cfg_r <= cfg_wdata[1:0];
          mwf_pkg::CFG_WIDTH:  width_cfg_r  <= cfg_wdata;
          mwf_pkg::CFG_HEIGHT: height_cfg_r <= cfg_wdata;
          default: ;
        endcase
        if (cfg_index == mwf_pkg::CFG_RADIUS || cfg_index == mwf_pkg::CFG_WIDTH ||
            cfg_index == mwf_pkg::CFG_HEIGHT) begin
          in_col_r   <= '0;
          in_row_r   <= '0;
          in_ring_r  <= '0;
          out_col_r  <= '0;
          out_row_r  <= '0;
          out_ring_r <= '0;
        end
      end
      if (accept) begin
        if (pix) begin
          if (row_end) begin
            in_col_r  <= '0;
            in_row_r  <= in_row_r + (ROW_W+1)'(1);
            in_ring_r <= (in_ring_r == RING_W'(mwf_pkg::RING_ROWS - 1)) ? '0
                                                                       : in_ring_r + 1'b1;
          end else begin
            in_col_r <= col_c + COL_W'(1);
          end
        end
        if (emit_cnt != '0) begin
          rem_r <= emit_cnt;
          dy_r  <= '0;
          dx_r  <= '0;
        end
      end
      if (cmd.rd_issue) begin
        if (dx_r == span) begin
          dx_r <= '0;
          dy_r <= dy_r + OFS_W'(1);
        end else begin
          dx_r <= dx_r + OFS_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        rem_r       <= rem_r - CNT_W'(1);
        dy_r        <= '0;
        dx_r        <= '0;
        if (frame_last) begin
          in_col_r   <= '0;
          in_row_r   <= '0;
          in_ring_r  <= '0;
          out_col_r  <= '0;
          out_row_r  <= '0;
          out_ring_r <= '0;
        end else if (out_col_r >= wm1) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + ROW_W'(1);
          out_ring_r <= (out_ring_r == RING_W'(mwf_pkg::RING_ROWS - 1)) ? '0
                                                                       : out_ring_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end else if (out_px.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // min/max accumulators and output word
  always_ff @(posedge clk) begin
    if ((accept && emit_cnt != '0) || cmd.emit) begin
      for (int c = 0; c < 3; c++) begin
        mn_r[c] <= 8'hFF;
        mx_r[c] <= 8'h00;
      end
    end else if (rd_vld_r) begin
      for (int c = 0; c < 3; c++) begin
        if (rd_data_r[16-8*c +: 8] < mn_r[c]) mn_r[c] <= rd_data_r[16-8*c +: 8];
        if (rd_data_r[16-8*c +: 8] > mx_r[c]) mx_r[c] <= rd_data_r[16-8*c +: 8];
      end
    end
    if (cmd.emit) begin
      out_red_r   <= mid_c[0];
      out_green_r <= mid_c[1];
      out_blue_r  <= mid_c[2];
      out_last_r  <= item_done;
      out_fend_r  <= frame_last;
    end
  end

  assign in_px.ready      = cmd.in_ready;
  assign out_px.valid     = out_valid_r;
  assign out_px.red_out   = out_red_r;
  assign out_px.green_out = out_green_r;
  assign out_px.blue_out  = out_blue_r;
  assign out_px.run_last  = out_last_r;
  assign out_px.frame_end = out_fend_r;

  assign sts.accept     = accept;
  assign sts.start_emit = emit_cnt != '0;
  assign sts.scan_last  = scan_last;
  assign sts.out_free   = !out_valid_r || out_px.ready;
  assign sts.item_done  = item_done;
endmodule

@@ bench/tb_midpoint_window_filter_core.sv @@
// Testbench for midpoint_window_filter_core: raster frames against a window predictor.
`timescale 1ns / 1ps
module tb_midpoint_window_filter_core;

  localparam int LIMIT = 1000000;
  localparam int SETTLE = 80;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       flush;
  } px_word_t;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       run_last;
    bit       frame_end;
  } mid_word_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [mwf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mwf_pkg::CFG_W-1:0]     cfg_wdata;

  mwf_in_if  in_px ();
  mwf_out_if out_px ();

  midpoint_window_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_px),
    .out_px    (out_px),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predictor state
  logic [23:0] line_mem [0:mwf_pkg::RING_ROWS*mwf_pkg::MAX_WIDTH-1];
  int          radius_reg, width_reg, height_reg;
  int          col_in, row_in, col_out, row_out;

  px_word_t  pending_px[$];
  mid_word_t midpoint_q[$];
  px_word_t  cur_px;

  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_on;
  bit  start_hold;
  int  hold_left = 0;
  int  counted;

  function automatic int eff_radius();
    return radius_reg > mwf_pkg::MAX_RADIUS ? mwf_pkg::MAX_RADIUS : radius_reg;
  endfunction

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    return width_reg > mwf_pkg::MAX_WIDTH ? mwf_pkg::MAX_WIDTH : width_reg;
  endfunction

  function automatic int eff_height();
    if (height_reg == 0) return 1;
    return height_reg > mwf_pkg::MAX_HEIGHT ? mwf_pkg::MAX_HEIGHT : height_reg;
  endfunction

  function automatic int clampi(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic mid_word_t window_midpoint();
    mid_word_t res;
    int r, w, h, ny, nx, lo[3], hi[3], v;
    logic [23:0] p;
    r = eff_radius();
    w = eff_width();
    h = eff_height();
    for (int c = 0; c < 3; c++) begin
      lo[c] = 255;
      hi[c] = 0;
    end
    for (int dy = -r; dy <= r; dy++) begin
      ny = clampi(row_out + dy, h - 1);
      for (int dx = -r; dx <= r; dx++) begin
        nx = clampi(col_out + dx, w - 1);
        p = line_mem[(ny % mwf_pkg::RING_ROWS) * mwf_pkg::MAX_WIDTH + nx];
        for (int c = 0; c < 3; c++) begin
          v = (p >> (16 - 8 * c)) & 8'hff;
          if (v < lo[c]) lo[c] = v;
          if (v > hi[c]) hi[c] = v;
        end
      end
    end
    res.red = 8'((lo[0] + hi[0]) >> 1);
    res.green = 8'((lo[1] + hi[1]) >> 1);
    res.blue = 8'((lo[2] + hi[2]) >> 1);
    res.run_last = 1'b0;
    res.frame_end = (row_out >= h - 1) && (col_out >= w - 1);
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    if (res.frame_end) begin
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
    end
    return res;
  endfunction

  task automatic filter_step(input px_word_t wd);
    mid_word_t res;
    int r, w, h, col, row, n, cnt;
    bit row_end;
    r = eff_radius();
    w = eff_width();
    h = eff_height();
    cnt = 0;
    if (row_in >= h) begin
      res = window_midpoint();
      res.run_last = 1'b1;
      midpoint_q.push_back(res);
      return;
    end
    if (wd.flush) return;
    col = col_in < w ? col_in : w - 1;
    row = row_in;
    row_end = col >= w - 1;
    line_mem[(row % mwf_pkg::RING_ROWS) * mwf_pkg::MAX_WIDTH + col] =
      {wd.red, wd.green, wd.blue};
    if (row_end) begin
      col_in = 0;
      row_in++;
    end else begin
      col_in = col + 1;
    end
    if (row >= r) begin
      if (row_end) begin
        n = col_out < w ? w - col_out : 0;
        if (n > mwf_pkg::BURST) n = mwf_pkg::BURST;
        for (int i = 0; i < n; i++) begin
          res = window_midpoint();
          midpoint_q.push_back(res);
          cnt++;
          if (res.frame_end) break;
        end
      end else if (col >= r) begin
        midpoint_q.push_back(window_midpoint());
        cnt++;
      end
    end
    if (cnt > 0) midpoint_q[$].run_last = 1'b1;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_px.valid <= 1'b0;
      in_px.red_in <= '0;
      in_px.green_in <= '0;
      in_px.blue_in <= '0;
      in_px.is_flush <= 1'b0;
    end else begin
      if (in_px.valid && in_px.ready) filter_step(cur_px);
      if (!in_px.valid || in_px.ready) begin
        if (pending_px.size() > 0 && !(idle_on && $urandom_range(99) < 8)) begin
          cur_px = pending_px.pop_front();
          in_px.red_in <= cur_px.red;
          in_px.green_in <= cur_px.green;
          in_px.blue_in <= cur_px.blue;
          in_px.is_flush <= cur_px.flush;
          in_px.valid <= 1'b1;
        end else begin
          in_px.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (start_hold) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    mid_word_t want;
    if (!rst_n) begin
      out_px.ready <= 1'b0;
    end else begin
      if (out_px.valid && out_px.ready) begin
        if (midpoint_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h %h %h",
            out_px.red_out, out_px.green_out, out_px.blue_out);
        end else begin
          want = midpoint_q.pop_front();
          if (out_px.red_out !== want.red || out_px.green_out !== want.green ||
              out_px.blue_out !== want.blue || out_px.run_last !== want.run_last ||
              out_px.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h l%0d e%0d got %h %h %h l%0d e%0d",
                want.red, want.green, want.blue, want.run_last, want.frame_end,
                out_px.red_out, out_px.green_out, out_px.blue_out,
                out_px.run_last, out_px.frame_end);
          end
        end
      end
      out_px.ready <= (hold_left == 0) && !(idle_on && $urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic set_reg(input mwf_pkg::cfg_idx_t idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= mwf_pkg::CFG_W'(val);
    case (idx)
      mwf_pkg::CFG_RADIUS: radius_reg = val & 3;
      mwf_pkg::CFG_WIDTH:  width_reg = val & 11'h7ff;
      default:             height_reg = val & 11'h7ff;
    endcase
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_px.size() > 0 || in_px.valid || midpoint_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic bit [7:0] make_sample(bit extreme);
    if (extreme) return $urandom_range(1) ? 8'hff : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic px_word_t make_px(bit extreme, bit flush);
    px_word_t p;
    p.red = make_sample(extreme);
    p.green = make_sample(extreme);
    p.blue = make_sample(extreme);
    p.flush = flush;
    return p;
  endfunction

  // npix pixels; full frames are drained, with some drain words sent as pixels
  task automatic queue_frame(input int npix, input bit drain, input bit extreme,
                             input int noise_pct, input int pix_drain_pct);
    int r, w, h, need;
    r = eff_radius();
    w = eff_width();
    h = eff_height();
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < noise_pct) pending_px.push_back(make_px(0, 1));
      pending_px.push_back(make_px(extreme, 0));
    end
    counted += npix;
    if (drain) begin
      need = (r < h ? r : h) * w;
      for (int i = 0; i < need; i++)
        pending_px.push_back(make_px(0, $urandom_range(99) >= pix_drain_pct));
      counted += need;
      if ($urandom_range(1)) pending_px.push_back(make_px(0, 1));
    end
  endtask

  task automatic config3(input int r, input int w, input int h);
    set_reg(mwf_pkg::CFG_RADIUS, r);
    set_reg(mwf_pkg::CFG_WIDTH, w);
    set_reg(mwf_pkg::CFG_HEIGHT, h);
  endtask

  initial begin
    int w, h, n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mwf_pkg::CFG_RADIUS;
    cfg_wdata = '0;
    idle_on = 1'b1;
    start_hold = 1'b0;
    counted = 0;
    radius_reg = 1;
    width_reg = 1024;
    height_reg = 1024;
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    config3(0, 3, 2);
    queue_frame(6, 1, 1, 20, 0);
    wait_idle();
    config3(1, 1, 1);
    queue_frame(1, 1, 1, 0, 0);
    wait_idle();
    config3(3, 3, 2);
    queue_frame(6, 1, 1, 30, 50);
    wait_idle();
    config3(3, 0, 0);
    queue_frame(1, 1, 0, 0, 100);
    wait_idle();

    // wide row and a very tall column, calm then held receiver
    idle_on = 1'b0;
    config3(1, 2047, 1);
    queue_frame(40, 0, 0, 0, 0);
    wait_idle();
    config3(3, 1, 2047);
    queue_frame(20, 0, 0, 0, 0);
    wait_idle();
    config3(2, 1024, 2);
    queue_frame(60, 0, 1, 0, 0);
    wait_idle();
    idle_on = 1'b1;
    config3(1, 8, 6);
    queue_frame(48, 1, 0, 5, 20);
    @(posedge clk);
    start_hold <= 1'b1;
    @(posedge clk);
    start_hold <= 1'b0;
    wait_idle();

    while (counted < 320) begin
      case ($urandom_range(3))
        0: set_reg(mwf_pkg::CFG_RADIUS, $urandom_range(3));
        1: set_reg(mwf_pkg::CFG_WIDTH, $urandom_range(1, 8));
        2: set_reg(mwf_pkg::CFG_HEIGHT, $urandom_range(1, 6));
        default: config3($urandom_range(3), $urandom_range(1, 8), $urandom_range(1, 6));
      endcase
      w = eff_width();
      h = eff_height();
      if ($urandom_range(9) < 8) begin
        queue_frame(w * h, 1, $urandom_range(7) == 0, 5, 10);
        if ($urandom_range(2) == 0) queue_frame(w * h, 1, 0, 5, 10);
      end else begin
        n = $urandom_range(w * h - 1 > 0 ? w * h - 1 : 0);
        queue_frame(n, 0, 0, 10, 0);
      end
      wait_idle();
    end

    wait_idle();
    if (mismatches == 0 && midpoint_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
